// ----- rtl/cng_pkg.sv -----
// ----------------------------------------------------------------------------
// cng_pkg: shared types, constants and helpers for the CJK n-gram tokenizer
// Code point classes, window cell layout, result and generator records.
// ----------------------------------------------------------------------------
package cng_pkg;

    localparam int CP_W          = 21;  // Unicode scalar value
    localparam int CNT_W         = 16;  // token counter / limit
    localparam int NG_W          = 3;   // ngram_size register
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 16;
    localparam int MAX_NGRAM_DEF = 4;

    localparam logic [NG_W-1:0]  NGRAM_RESET = 3'd2;
    localparam logic [CNT_W-1:0] MAXTOK_RESET = '0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NGRAM_SIZE = 1'b0,
        REG_MAX_TOKENS = 1'b1
    } cfg_reg_t;

    // one window entry, classified once on load
    typedef struct packed {
        logic [CP_W-1:0] cp;
        logic            cjk;
        logic            brk;
    } cell_t;

    // one result item before the last flag is known
    typedef struct packed {
        logic [CP_W-1:0] ch;
        logic            cv;
        logic            te;
    } res_t;

    // sequencer -> output buffer
    typedef struct packed {
        logic emit;     // new result this cycle
        logic finish;   // transaction done, flush pending result as last
        res_t res;
    } gen_t;

    function automatic logic is_cjk(input logic [CP_W-1:0] c);
        return c inside {[21'h02E80:21'h02EFF], [21'h03000:21'h09FFF],
                         [21'h0A700:21'h0A71F], [21'h0AC00:21'h0D7AF],
                         [21'h0F900:21'h0FAFF], [21'h0FE30:21'h0FE4F],
                         [21'h0FF00:21'h0FFEF], [21'h20000:21'h2A6DF],
                         [21'h2F800:21'h2FA1F]};
    endfunction

    // ASCII that is not [0-9A-Za-z]
    function automatic logic is_brk(input logic [CP_W-1:0] c);
        return (c < 21'h80) &&
               !(c inside {[21'h30:21'h39], [21'h41:21'h5A], [21'h61:21'h7A]});
    endfunction

    function automatic cell_t classify(input logic [CP_W-1:0] c);
        cell_t r;
        r.cp  = c;
        r.cjk = is_cjk(c);
        r.brk = is_brk(c);
        return r;
    endfunction

endpackage

// ----- rtl/cng_cell.sv -----
// ----------------------------------------------------------------------------
// cng_cell: one lookahead window slot
// Loads and classifies a new code point, or takes its neighbor's entry on shift.
// ----------------------------------------------------------------------------
module cng_cell (
    input  logic                   clk,
    input  logic                   load_en,
    input  logic                   shift_en,
    input  logic [cng_pkg::CP_W-1:0] load_cp,
    input  cng_pkg::cell_t         nbr,
    output cng_pkg::cell_t         q
);
    import cng_pkg::*;

    cell_t slot_reg;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            slot_reg <= classify(load_cp);
        end
        else if (shift_en)
        begin
            slot_reg <= nbr;
        end
    end

    assign q = slot_reg;

endmodule

// ----- rtl/cng_seq.sv -----
// ----------------------------------------------------------------------------
// cng_seq: tokenizer sequencer
// Walks the window head, emits run characters, end markers and n-gram prefixes.
// ----------------------------------------------------------------------------
module cng_seq #(
    parameter int MAX_NGRAM = cng_pkg::MAX_NGRAM_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      end_of_text,
    input  logic [cng_pkg::NG_W-1:0]  ng_size_cfg,
    input  logic [cng_pkg::CNT_W-1:0] max_tokens,
    input  cng_pkg::cell_t            win [MAX_NGRAM],
    output logic [MAX_NGRAM-1:0]      load_en,
    output logic                      shift_en,
    input  logic                      room,
    output cng_pkg::gen_t             gen
);
    import cng_pkg::*;

    localparam int FILL_W = $clog2(MAX_NGRAM + 1);
    localparam int IDX_W  = (MAX_NGRAM > 1) ? $clog2(MAX_NGRAM) : 1;
    localparam int CW     = (FILL_W > NG_W) ? FILL_W : NG_W;

    typedef enum logic [5:0] {
        ST_IDLE     = 6'b000001,
        ST_DECIDE   = 6'b000010,
        ST_HEAD     = 6'b000100,
        ST_NG_START = 6'b001000,
        ST_NG_EMIT  = 6'b010000,
        ST_SHIFT    = 6'b100000
    } state_t;

    state_t             state_reg, state_next;
    logic [FILL_W-1:0]  fill_reg, fill_next;
    logic [FILL_W-1:0]  pop_w_reg, pop_w_next;
    logic [FILL_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic               eot_reg, eot_next;
    logic               run_open_reg, run_open_next;
    logic [CNT_W-1:0]   tok_reg, tok_next;

    logic [CW-1:0]      ng_ext;
    logic [CW-1:0]      size_ext;
    logic [FILL_W-1:0]  size;
    logic               limit_hit;
    logic [CNT_W-1:0]   tok_inc;
    cell_t              head, sel_i, sel_j;
    res_t               marker;

    // clamp window size to 1..MAX_NGRAM
    assign ng_ext   = CW'(ng_size_cfg);
    assign size_ext = (ng_ext == '0) ? CW'(1) :
                      (ng_ext > CW'(MAX_NGRAM)) ? CW'(MAX_NGRAM) : ng_ext;
    assign size     = FILL_W'(size_ext);

    assign limit_hit = (max_tokens != '0) && (tok_reg >= max_tokens);
    assign tok_inc   = (tok_reg != '1) ? tok_reg + CNT_W'(1) : tok_reg;

    assign head  = win[0];
    assign sel_i = win[i_reg[IDX_W-1:0]];
    assign sel_j = win[j_reg];

    assign marker = '{ch: '0, cv: 1'b0, te: 1'b1};

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        fill_next     = fill_reg;
        pop_w_next    = pop_w_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        eot_next      = eot_reg;
        run_open_next = run_open_reg;
        tok_next      = tok_reg;
        load_en       = '0;
        shift_en      = 1'b0;
        gen           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    // window never holds MAX_NGRAM entries between items
                    for (int k = 0; k < MAX_NGRAM; k++)
                    begin
                        load_en[k] = (fill_reg == FILL_W'(k));
                    end
                    fill_next  = fill_reg + FILL_W'(1);
                    eot_next   = end_of_text;
                    state_next = ST_DECIDE;
                end
            end

            ST_DECIDE:
            begin
                if ((fill_reg >= size) && (fill_reg != '0))
                begin
                    pop_w_next = size;
                    i_next     = '0;
                    state_next = ST_HEAD;
                end
                else if (eot_reg && (fill_reg != '0))
                begin
                    pop_w_next = fill_reg;
                    i_next     = '0;
                    state_next = ST_HEAD;
                end
                else if (eot_reg)
                begin
                    // close the run, then clear per-text state
                    if (!run_open_reg || room)
                    begin
                        gen.emit      = run_open_reg;
                        gen.res       = marker;
                        tok_next      = '0;
                        run_open_next = 1'b0;
                        eot_next      = 1'b0;
                    end
                end
                else if (room)
                begin
                    gen.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_HEAD:
            begin
                if (head.cjk || head.brk)
                begin
                    if (!run_open_reg)
                    begin
                        state_next = head.cjk ? ST_NG_START : ST_SHIFT;
                    end
                    else if (room)
                    begin
                        gen.emit      = 1'b1;
                        gen.res       = marker;
                        tok_next      = tok_inc;
                        run_open_next = 1'b0;
                        state_next    = head.cjk ? ST_NG_START : ST_SHIFT;
                    end
                end
                else if (run_open_reg || !limit_hit)
                begin
                    if (room)
                    begin
                        gen.emit      = 1'b1;
                        gen.res       = '{ch: head.cp, cv: 1'b1, te: 1'b0};
                        run_open_next = 1'b1;
                        state_next    = ST_SHIFT;
                    end
                end
                else
                begin
                    state_next = ST_SHIFT;
                end
            end

            ST_NG_START:
            begin
                if ((i_reg >= pop_w_reg) || limit_hit)
                begin
                    state_next = ST_SHIFT;
                end
                else if (!sel_i.cjk)
                begin
                    i_next = i_reg + FILL_W'(1);
                end
                else if (room)
                begin
                    // prefix always starts at the head
                    gen.emit = 1'b1;
                    gen.res  = '{ch: head.cp, cv: 1'b1, te: (i_reg == '0)};
                    if (i_reg == '0)
                    begin
                        tok_next = tok_inc;
                        i_next   = i_reg + FILL_W'(1);
                    end
                    else
                    begin
                        j_next     = IDX_W'(1);
                        state_next = ST_NG_EMIT;
                    end
                end
            end

            ST_NG_EMIT:
            begin
                if (!sel_j.cjk)
                begin
                    j_next = j_reg + IDX_W'(1);
                end
                else if (room)
                begin
                    gen.emit = 1'b1;
                    gen.res  = '{ch: sel_j.cp, cv: 1'b1, te: (FILL_W'(j_reg) == i_reg)};
                    if (FILL_W'(j_reg) == i_reg)
                    begin
                        tok_next   = tok_inc;
                        i_next     = i_reg + FILL_W'(1);
                        state_next = ST_NG_START;
                    end
                    else
                    begin
                        j_next = j_reg + IDX_W'(1);
                    end
                end
            end

            ST_SHIFT:
            begin
                shift_en   = 1'b1;
                fill_next  = fill_reg - FILL_W'(1);
                state_next = ST_DECIDE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            fill_reg     <= '0;
            eot_reg      <= 1'b0;
            run_open_reg <= 1'b0;
            tok_reg      <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_reg     <= fill_next;
            eot_reg      <= eot_next;
            run_open_reg <= run_open_next;
            tok_reg      <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pop_w_reg <= pop_w_next;
        i_reg     <= i_next;
        j_reg     <= j_next;
    end

endmodule

// ----- rtl/cng_obuf.sv -----
// ----------------------------------------------------------------------------
// cng_obuf: result staging
// Holds the newest result until its last flag is known, then the output register.
// ----------------------------------------------------------------------------
module cng_obuf (
    input  logic                     clk,
    input  logic                     rst_n,
    input  cng_pkg::gen_t            gen,
    output logic                     room,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [cng_pkg::CP_W-1:0] out_char,
    output logic                     char_valid,
    output logic                     token_end,
    output logic                     last
);
    import cng_pkg::*;

    res_t pend_reg, pend_next;
    logic pend_valid_reg, pend_valid_next;
    res_t out_reg, out_next;
    logic out_last_reg, out_last_next;
    logic out_valid_reg, out_valid_next;
    logic out_free;
    logic out_load;

    assign out_free = !out_valid_reg || !out_stall;
    assign room     = !pend_valid_reg || out_free;

    always_comb
    begin
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        out_load        = 1'b0;

        if (gen.emit)
        begin
            pend_next       = gen.res;
            pend_valid_next = 1'b1;
            if (pend_valid_reg)
            begin
                out_load      = 1'b1;
                out_next      = pend_reg;
                out_last_next = 1'b0;
            end
        end
        else if (gen.finish && pend_valid_reg)
        begin
            out_load        = 1'b1;
            out_next        = pend_reg;
            out_last_next   = 1'b1;
            pend_valid_next = 1'b0;
        end

        out_valid_next = out_load ? 1'b1 : (out_free ? 1'b0 : out_valid_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_char   = out_reg.ch;
    assign char_valid = out_reg.cv;
    assign token_end  = out_reg.te;
    assign last       = out_last_reg;

endmodule

// ----- rtl/cjk_ngram_tokenizer.sv -----
// ----------------------------------------------------------------------------
// cjk_ngram_tokenizer: streaming CJK n-gram / run tokenizer
// Code points in, token characters and end markers out, one transaction each.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (in_valid / in_stall): one decoded code point per transaction,
//   end_of_text marks the final one of a text. in_stall is high while an item
//   is in work; the block takes one item at a time.
//   Output channel (out_valid / out_stall): one result per transaction; last
//   is set on the final result an input causes. Items that cause no result
//   produce nothing on this side.
//   Config channel (cfg_valid / cfg_ready / cfg_index / cfg_data): window size
//   and token limit, always ready; write only while no item is in work.
// Timing
//   An item that pops nothing is accepted, then finished. Each window pop
//   adds a head, a shift and a decide step; a CJK head also adds a step per
//   n-gram character, per skipped non-CJK slot and one to end its walk.
//   End of text adds a step for the run close. At most one result per cycle.
//   A result shows on the output in the cycle after the next one is produced
//   (or after the item finishes), since last is resolved late.
// Reset / stall
//   Reset empties the window, closes any run and clears the token count.
//   A stalled output holds its result; the sequencer waits once its one-deep
//   pending stage is also full, and no result is dropped.
// ----------------------------------------------------------------------------
module cjk_ngram_tokenizer #(
    parameter int MAX_NGRAM = cng_pkg::MAX_NGRAM_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // input items
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [cng_pkg::CP_W-1:0]       code_point,
    input  logic                           end_of_text,
    // result items
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [cng_pkg::CP_W-1:0]       out_char,
    output logic                           char_valid,
    output logic                           token_end,
    output logic                           last,
    // configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [cng_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cng_pkg::CFG_DATA_W-1:0] cfg_data
);
    import cng_pkg::*;

    logic [NG_W-1:0]      ng_size_reg;
    logic [CNT_W-1:0]     max_tokens_reg;

    cell_t                win [MAX_NGRAM];
    logic [MAX_NGRAM-1:0] load_en;
    logic                 shift_en;
    logic                 room;
    gen_t                 gen;

    // Config registers; the port never pushes back.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ng_size_reg    <= NGRAM_RESET;
            max_tokens_reg <= MAXTOK_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_NGRAM_SIZE: ng_size_reg    <= cfg_data[NG_W-1:0];
                REG_MAX_TOKENS: max_tokens_reg <= cfg_data[CNT_W-1:0];
                default:        ;
            endcase
        end
    end

    // Lookahead window: a row of cells, slot 0 is the head. New code points
    // land at the fill position; a pop moves every entry one slot toward
    // the head.
    for (genvar g = 0; g < MAX_NGRAM; g++)
    begin : g_cell
        cell_t nbr;

        if (g == MAX_NGRAM - 1)
        begin : g_tail
            assign nbr = '0;
        end
        else
        begin : g_mid
            assign nbr = win[g+1];
        end

        cng_cell u_cell (
            .clk      (clk),
            .load_en  (load_en[g]),
            .shift_en (shift_en),
            .load_cp  (code_point),
            .nbr      (nbr),
            .q        (win[g])
        );
    end

    // Sequencer: decides pops, walks n-gram prefixes, tracks run and count.
    cng_seq #(
        .MAX_NGRAM (MAX_NGRAM)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .end_of_text (end_of_text),
        .ng_size_cfg (ng_size_reg),
        .max_tokens  (max_tokens_reg),
        .win         (win),
        .load_en     (load_en),
        .shift_en    (shift_en),
        .room        (room),
        .gen         (gen)
    );

    // Pending stage plus output register; resolves the last flag.
    cng_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .gen        (gen),
        .room       (room),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_char   (out_char),
        .char_valid (char_valid),
        .token_end  (token_end),
        .last       (last)
    );

endmodule

// ----- rtl/cng_checker.sv -----
// ----------------------------------------------------------------------------
// cng_checker: port-level checks for the tokenizer
// Watches the top-level channels; attached by bind.
// ----------------------------------------------------------------------------
module cng_checker (
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic [cng_pkg::CP_W-1:0] out_char,
    input logic                     char_valid,
    input logic                     token_end,
    input logic                     last
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_char) &&
            $stable(char_valid) && $stable(token_end) && $stable(last))
        else $error("output changed while stalled");

    // bare end marker carries no character and closes a token
    a_marker: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !char_valid |-> token_end && (out_char == '0))
        else $error("malformed end marker");

    // only characters may leave a token open
    a_open_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !token_end |-> char_valid)
        else $error("open token result without character");

    // one item at a time: accepted item blocks the input next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted back to back");

endmodule

bind cjk_ngram_tokenizer cng_checker u_cng_checker (.*);
